@@ rtl/rsi_pkg.sv @@
// shared widths and types for the ray sphere intersect unit
package rsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int R_W       = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd3;

    localparam int OC_W   = W + 1;
    localparam int PROD_W = OC_W + W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int SQR_W  = 2 * OC_W;
    localparam int LEN_W  = SQR_W + 2;
    localparam int RSQ_W  = 2 * R_W;
    localparam int C_W    = LEN_W + 1;
    localparam int B_W    = DOT_W - FRAC_BITS;
    localparam int LO_W   = (B_W + 1) / 2;
    localparam int HI_W   = B_W - LO_W;
    localparam int BSQ_W  = 2 * B_W;
    localparam int DISC_W = ((BSQ_W > C_W) ? BSQ_W : C_W) + 1;
    localparam int SQ_W   = DISC_W / 2;
    localparam int X_W    = 2 * SQ_W;
    localparam int REM_W  = SQ_W + 2;
    localparam int RT_W   = ((B_W > SQ_W) ? B_W : SQ_W) + 2;

    typedef struct packed {
        logic                  miss;
        logic signed [B_W-1:0] b;
        logic signed [W-1:0]   tmin;
        logic signed [W-1:0]   tmax;
    } rsi_side_t;

endpackage

@@ rtl/ray_sphere_intersect_unit.sv @@
// top level of the ray sphere intersect unit
// Fully pipelined ray against sphere test on Q16.16 data: one ray transaction
// is accepted per clock while no result waits at the output, else the whole
// pipeline holds. Each result passes seven arithmetic stages, one square root
// stage per result bit and the output register. Sphere center and radius come
// from the write port; the user must change them only while no transaction is
// in flight, and the block itself does not enforce this.
module ray_sphere_intersect_unit
    import rsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [W-1:0]         cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  origin_x,
    input  logic signed [W-1:0]  origin_y,
    input  logic signed [W-1:0]  origin_z,
    input  logic signed [W-1:0]  dir_x,
    input  logic signed [W-1:0]  dir_y,
    input  logic signed [W-1:0]  dir_z,
    input  logic signed [W-1:0]  window_min,
    input  logic signed [W-1:0]  window_max,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit_found,
    output logic signed [W-1:0]  hit_distance,
    output logic                 far_root
);

    logic signed [W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [R_W-1:0]      radius_reg;
    logic                en;

    logic             v_w    [0:SQ_W];
    logic [X_W-1:0]   x_w    [0:SQ_W];
    logic [SQ_W-1:0]  root_w [0:SQ_W];
    logic [REM_W-1:0] rem_w  [0:SQ_W];
    rsi_side_t        side_w [0:SQ_W];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= R_W'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[R_W-1:0];
                default:      ;
            endcase
        end
    end

    rsi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .origin_z      (origin_z),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .window_min    (window_min),
        .window_max    (window_max),
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .center_z      (center_z_reg),
        .sphere_radius (radius_reg),
        .out_valid     (v_w[0]),
        .disc_out      (x_w[0]),
        .side_out      (side_w[0])
    );

    assign root_w[0] = '0;
    assign rem_w[0]  = '0;

    genvar i;
    generate
        for (i = 0; i < SQ_W; i++)
        begin : g_sqrt
            rsi_sqrt_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (v_w[i]),
                .x_in      (x_w[i]),
                .root_in   (root_w[i]),
                .rem_in    (rem_w[i]),
                .side_in   (side_w[i]),
                .out_valid (v_w[i+1]),
                .x_out     (x_w[i+1]),
                .root_out  (root_w[i+1]),
                .rem_out   (rem_w[i+1]),
                .side_out  (side_w[i+1])
            );
        end
    endgenerate

    rsi_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (v_w[SQ_W]),
        .root_in      (root_w[SQ_W]),
        .side_in      (side_w[SQ_W]),
        .out_valid    (out_valid),
        .hit_found    (hit_found),
        .hit_distance (hit_distance),
        .far_root     (far_root)
    );

endmodule

@@ rtl/rsi_front.sv @@
// front stages: offset, products, sums, b squared and discriminant
module rsi_front
    import rsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   origin_x,
    input  logic signed [W-1:0]   origin_y,
    input  logic signed [W-1:0]   origin_z,
    input  logic signed [W-1:0]   dir_x,
    input  logic signed [W-1:0]   dir_y,
    input  logic signed [W-1:0]   dir_z,
    input  logic signed [W-1:0]   window_min,
    input  logic signed [W-1:0]   window_max,
    input  logic signed [W-1:0]   center_x,
    input  logic signed [W-1:0]   center_y,
    input  logic signed [W-1:0]   center_z,
    input  logic        [R_W-1:0] sphere_radius,
    output logic                  out_valid,
    output logic        [X_W-1:0] disc_out,
    output rsi_side_t             side_out
);

    logic [7:1] v_reg;

    // stage 1
    logic signed [OC_W-1:0] ocx_reg, ocy_reg, ocz_reg;
    logic signed [W-1:0]    dx_reg, dy_reg, dz_reg;
    logic signed [W-1:0]    tmin1_reg, tmax1_reg;
    logic                   miss1_reg;
    // stage 2
    logic signed [PROD_W-1:0] pdx_reg, pdy_reg, pdz_reg;
    logic signed [SQR_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic        [RSQ_W-1:0]  rsq_reg;
    logic signed [W-1:0]      tmin2_reg, tmax2_reg;
    logic                     miss2_reg;
    // stage 3
    logic signed [DOT_W-1:0] dot_reg;
    logic signed [C_W-1:0]   c3_reg;
    logic signed [W-1:0]     tmin3_reg, tmax3_reg;
    logic                    miss3_reg;
    // stage 4
    logic        [B_W-1:0]   mag_reg;
    logic signed [C_W-1:0]   c4_reg;
    rsi_side_t               side4_reg;
    // stage 5
    logic [2*LO_W-1:0]       ll_reg;
    logic [LO_W+HI_W-1:0]    lh_reg;
    logic [2*HI_W-1:0]       hh_reg;
    logic signed [C_W-1:0]   c5_reg;
    rsi_side_t               side5_reg;
    // stage 6
    logic [BSQ_W-1:0]        bsq_reg;
    logic signed [C_W-1:0]   c6_reg;
    rsi_side_t               side6_reg;
    // stage 7
    logic [X_W-1:0]          x_reg;
    rsi_side_t               side7_reg;

    logic signed [OC_W-1:0]   ocx_next, ocy_next, ocz_next;
    logic signed [PROD_W-1:0] pdx_next, pdy_next, pdz_next;
    logic signed [SQR_W-1:0]  sqx_next, sqy_next, sqz_next;
    logic        [RSQ_W-1:0]  rsq_next;
    logic signed [DOT_W-1:0]  dot_next;
    logic signed [LEN_W-1:0]  len_next;
    logic signed [C_W-1:0]    c_next;
    logic signed [B_W-1:0]    b_next;
    logic        [B_W-1:0]    mag_next;
    logic [LO_W-1:0]          lo_w;
    logic [HI_W-1:0]          hi_w;
    logic [BSQ_W-1:0]         bsq_next;
    logic signed [DISC_W-1:0] disc_next;
    rsi_side_t                side7_next;

    always_comb
    begin
        ocx_next = OC_W'(origin_x) - OC_W'(center_x);
        ocy_next = OC_W'(origin_y) - OC_W'(center_y);
        ocz_next = OC_W'(origin_z) - OC_W'(center_z);
        pdx_next = ocx_reg * dx_reg;
        pdy_next = ocy_reg * dy_reg;
        pdz_next = ocz_reg * dz_reg;
        sqx_next = ocx_reg * ocx_reg;
        sqy_next = ocy_reg * ocy_reg;
        sqz_next = ocz_reg * ocz_reg;
        rsq_next = RSQ_W'(sphere_radius) * RSQ_W'(sphere_radius);
        dot_next = DOT_W'(pdx_reg) + DOT_W'(pdy_reg) + DOT_W'(pdz_reg);
        len_next = LEN_W'(sqx_reg) + LEN_W'(sqy_reg) + LEN_W'(sqz_reg);
        c_next   = C_W'(len_next) - $signed(C_W'(rsq_reg));
        b_next   = dot_reg[DOT_W-1:FRAC_BITS];
        mag_next = b_next[B_W-1] ? B_W'(-b_next) : B_W'(b_next);
        lo_w     = mag_reg[LO_W-1:0];
        hi_w     = mag_reg[B_W-1:LO_W];
        bsq_next = (BSQ_W'(hh_reg) << (2 * LO_W)) + (BSQ_W'(lh_reg) << (LO_W + 1))
                 + BSQ_W'(ll_reg);
        disc_next = $signed(DISC_W'(bsq_reg)) - DISC_W'(c6_reg);
        side7_next = side6_reg;
        side7_next.miss = side6_reg.miss | disc_next[DISC_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ocx_reg   <= ocx_next;
            ocy_reg   <= ocy_next;
            ocz_reg   <= ocz_next;
            dx_reg    <= dir_x;
            dy_reg    <= dir_y;
            dz_reg    <= dir_z;
            tmin1_reg <= window_min;
            tmax1_reg <= window_max;
            miss1_reg <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);

            pdx_reg   <= pdx_next;
            pdy_reg   <= pdy_next;
            pdz_reg   <= pdz_next;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            sqz_reg   <= sqz_next;
            rsq_reg   <= rsq_next;
            tmin2_reg <= tmin1_reg;
            tmax2_reg <= tmax1_reg;
            miss2_reg <= miss1_reg;

            dot_reg   <= dot_next;
            c3_reg    <= c_next;
            tmin3_reg <= tmin2_reg;
            tmax3_reg <= tmax2_reg;
            miss3_reg <= miss2_reg;

            mag_reg        <= mag_next;
            c4_reg         <= c3_reg;
            side4_reg.miss <= miss3_reg;
            side4_reg.b    <= b_next;
            side4_reg.tmin <= tmin3_reg;
            side4_reg.tmax <= tmax3_reg;

            ll_reg    <= (2*LO_W)'(lo_w) * (2*LO_W)'(lo_w);
            lh_reg    <= (LO_W+HI_W)'(lo_w) * (LO_W+HI_W)'(hi_w);
            hh_reg    <= (2*HI_W)'(hi_w) * (2*HI_W)'(hi_w);
            c5_reg    <= c4_reg;
            side5_reg <= side4_reg;

            bsq_reg   <= bsq_next;
            c6_reg    <= c5_reg;
            side6_reg <= side5_reg;

            x_reg     <= X_W'(disc_next[DISC_W-2:0]);
            side7_reg <= side7_next;
        end
    end

    assign out_valid = v_reg[7];
    assign disc_out  = x_reg;
    assign side_out  = side7_reg;

endmodule

@@ rtl/rsi_sqrt_step.sv @@
// one registered step of the digit by digit square root
module rsi_sqrt_step
    import rsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [X_W-1:0]   x_in,
    input  logic [SQ_W-1:0]  root_in,
    input  logic [REM_W-1:0] rem_in,
    input  rsi_side_t        side_in,
    output logic             out_valid,
    output logic [X_W-1:0]   x_out,
    output logic [SQ_W-1:0]  root_out,
    output logic [REM_W-1:0] rem_out,
    output rsi_side_t        side_out
);

    logic             valid_reg;
    logic [X_W-1:0]   x_reg;
    logic [SQ_W-1:0]  root_reg;
    logic [REM_W-1:0] rem_reg;
    rsi_side_t        side_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb
    begin
        rem_sh = {rem_in[REM_W-3:0], x_in[X_W-1:X_W-2]};
        trial  = {root_in, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= {x_in[X_W-3:0], 2'b00};
            root_reg <= {root_in[SQ_W-2:0], take};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign root_out  = root_reg;
    assign rem_out   = rem_reg;
    assign side_out  = side_reg;

endmodule

@@ rtl/rsi_select.sv @@
// root selection against the window and output register
module rsi_select
    import rsi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SQ_W-1:0]     root_in,
    input  rsi_side_t           side_in,
    output logic                out_valid,
    output logic                hit_found,
    output logic signed [W-1:0] hit_distance,
    output logic                far_root
);

    logic                valid_reg;
    logic                hit_reg;
    logic signed [W-1:0] dist_reg;
    logic                far_reg;

    logic signed [RT_W-1:0] nb, s_ext, near_t, far_t, lo_t, hi_t;
    logic                   near_ok, far_ok;

    always_comb
    begin
        nb      = -RT_W'(side_in.b);
        s_ext   = $signed(RT_W'(root_in));
        near_t  = nb - s_ext;
        far_t   = nb + s_ext;
        lo_t    = RT_W'(side_in.tmin);
        hi_t    = RT_W'(side_in.tmax);
        near_ok = !side_in.miss && (near_t >= lo_t) && (near_t <= hi_t);
        far_ok  = !side_in.miss && (far_t >= lo_t) && (far_t <= hi_t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= near_ok || far_ok;
            far_reg <= !near_ok && far_ok;
            if (near_ok)
            begin
                dist_reg <= near_t[W-1:0];
            end
            else if (far_ok)
            begin
                dist_reg <= far_t[W-1:0];
            end
            else
            begin
                dist_reg <= '0;
            end
        end
    end

    assign out_valid    = valid_reg;
    assign hit_found    = hit_reg;
    assign hit_distance = dist_reg;
    assign far_root     = far_reg;

endmodule

@@ dv/ray_sphere_intersect_checker.sv @@
// transaction monitor, hit predictor and result comparator for the ray sphere intersect unit
`timescale 1ns / 100ps
module ray_sphere_intersect_checker
    import rsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [W-1:0]         cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic signed [W-1:0]  origin_x,
    input  logic signed [W-1:0]  origin_y,
    input  logic signed [W-1:0]  origin_z,
    input  logic signed [W-1:0]  dir_x,
    input  logic signed [W-1:0]  dir_y,
    input  logic signed [W-1:0]  dir_z,
    input  logic signed [W-1:0]  window_min,
    input  logic signed [W-1:0]  window_max,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 hit_found,
    input  logic signed [W-1:0]  hit_distance,
    input  logic                 far_root,
    output int                   fail_count,
    output int                   hits_pending
);

    typedef struct packed {
        logic                hit;
        logic signed [W-1:0] distance;
        logic                far;
    } hit_t;

    logic signed [W-1:0] sph_cx;
    logic signed [W-1:0] sph_cy;
    logic signed [W-1:0] sph_cz;
    logic [R_W-1:0]      sph_r;
    hit_t                hit_q[$];
    int                  fails = 0;

    assign fail_count   = fails;
    assign hits_pending = hit_q.size();

    function automatic logic [127:0] floor_sqrt(logic [127:0] x);
        logic [127:0] res;
        logic [127:0] cand;
        res = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = res | (128'd1 << i);
            if (cand * cand <= x)
                res = cand;
        end
        return res;
    endfunction

    function automatic hit_t trace_sphere(logic signed [W-1:0] ox_in, logic signed [W-1:0] oy_in,
                                          logic signed [W-1:0] oz_in, logic signed [W-1:0] dx_in,
                                          logic signed [W-1:0] dy_in, logic signed [W-1:0] dz_in,
                                          logic signed [W-1:0] tlo, logic signed [W-1:0] thi);
        logic signed [127:0] ox, oy, oz, dx, dy, dz, rr, dot, bw, len2, cval, disc, sq, root;
        logic signed [127:0] lo, hi;
        hit_t res;
        res = '0;
        ox = 128'(ox_in) - 128'(sph_cx);
        oy = 128'(oy_in) - 128'(sph_cy);
        oz = 128'(oz_in) - 128'(sph_cz);
        dx = dx_in;
        dy = dy_in;
        dz = dz_in;
        rr = $signed({97'd0, sph_r});
        lo = tlo;
        hi = thi;
        if (dx_in == 0 && dy_in == 0 && dz_in == 0)
            return res;
        dot  = ox * dx + oy * dy + oz * dz;
        bw   = dot >>> FRAC_BITS;
        len2 = ox * ox + oy * oy + oz * oz;
        cval = len2 - rr * rr;
        disc = bw * bw - cval;
        if (disc[127])
            return res;
        sq = $signed(floor_sqrt(disc));
        root = -bw - sq;
        if (root >= lo && root <= hi)
        begin
            res.hit      = 1'b1;
            res.distance = root[W-1:0];
            return res;
        end
        root = -bw + sq;
        if (root >= lo && root <= hi)
        begin
            res.hit      = 1'b1;
            res.distance = root[W-1:0];
            res.far      = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hit_t want;
        if (!rst_n)
        begin
            sph_cx <= '0;
            sph_cy <= '0;
            sph_cz <= '0;
            sph_r  <= R_W'(1 << FRAC_BITS);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CENTER_X: sph_cx <= cfg_data;
                    REG_CENTER_Y: sph_cy <= cfg_data;
                    REG_CENTER_Z: sph_cz <= cfg_data;
                    REG_RADIUS:   sph_r  <= cfg_data[R_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                hit_q.push_back(trace_sphere(origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                                             window_min, window_max));
            if (out_valid && out_ready)
            begin
                if (hit_q.size() == 0)
                    report_mismatch("unexpected transaction", 64'(hit_found), 64'd0);
                else
                begin
                    want = hit_q.pop_front();
                    if (hit_found !== want.hit)
                        report_mismatch("hit_found", 64'(hit_found), 64'(want.hit));
                    if (hit_distance !== want.distance)
                        report_mismatch("hit_distance", 64'(hit_distance), 64'(want.distance));
                    if (far_root !== want.far)
                        report_mismatch("far_root", 64'(far_root), 64'(want.far));
                end
            end
        end
    end

endmodule

@@ dv/ray_sphere_intersect_unit_test.sv @@
// stimulus, flow control and verdict for the ray sphere intersect unit
`timescale 1ns / 100ps
module ray_sphere_intersect_unit_test;
    import rsi_pkg::*;

    localparam int LIMIT = 600000;
    localparam int ONE   = 1 << FRAC_BITS;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [W-1:0]         cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [W-1:0]  origin_x, origin_y, origin_z;
    logic signed [W-1:0]  dir_x, dir_y, dir_z;
    logic signed [W-1:0]  window_min, window_max;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit_found;
    logic signed [W-1:0]  hit_distance;
    logic                 far_root;
    int                   fail_count;
    int                   hits_pending;
    int                   idle_mode;
    logic                 long_hold;
    logic                 hold_start;
    int                   cycles = 0;

    ray_sphere_intersect_unit DUT (.*);

    ray_sphere_intersect_checker checker_i (.*);

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        long_hold = 1'b0;
        wait (hold_start);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (long_hold)
            out_ready <= 1'b0;
        else if (idle_mode == 2)
            out_ready <= $urandom_range(99) >= 73;
        else if (idle_mode == 3)
            out_ready <= $urandom_range(99) >= 19;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("ray_sphere_intersect_unit_test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_ray(logic signed [W-1:0] ox, logic signed [W-1:0] oy,
                            logic signed [W-1:0] oz, logic signed [W-1:0] dx,
                            logic signed [W-1:0] dy, logic signed [W-1:0] dz,
                            logic signed [W-1:0] tlo, logic signed [W-1:0] thi);
        int gap;
        int pct;
        logic acc;
        gap = 0;
        pct = (idle_mode == 1) ? 73 : ((idle_mode == 3) ? 19 : 0);
        while ($urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        origin_x   <= ox;
        origin_y   <= oy;
        origin_z   <= oz;
        dir_x      <= dx;
        dir_y      <= dy;
        dir_z      <= dz;
        window_min <= tlo;
        window_max <= thi;
        do
        begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end
        while (!acc);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (hits_pending != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    function automatic logic signed [W-1:0] near_val();
        return $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
    endfunction

    task automatic send_random();
        logic signed [W-1:0] d[3];
        logic signed [W-1:0] tlo, thi;
        int axis;
        if ($urandom_range(99) < 15)
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        else
        begin
            d[0] = 0;
            d[1] = 0;
            d[2] = 0;
            if ($urandom_range(1))
            begin
                axis = $urandom_range(2);
                d[axis] = $urandom_range(1) ? ONE : -ONE;
            end
            else
                foreach (d[i])
                    d[i] = $signed($urandom_range(0, 2 * ONE)) - ONE;
            tlo = $signed($urandom_range(0, 3 * ONE)) - 2 * ONE;
            thi = tlo + $signed($urandom_range(0, 20 * ONE));
            if ($urandom_range(99) < 8)
                thi = tlo - 1;
            send_ray(near_val(), near_val(), near_val(), d[0], d[1], d[2], tlo, thi);
        end
    endtask

    initial
    begin
        logic [W-1:0] cx, cy, cz, rad;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        origin_x   = '0;
        origin_y   = '0;
        origin_z   = '0;
        dir_x      = '0;
        dir_y      = '0;
        dir_z      = '0;
        window_min = '0;
        window_max = '0;
        idle_mode  = 0;
        hold_start = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rays against the unit sphere at the origin
        send_ray(-4 * ONE, 0, 0, ONE, 0, 0, 0, 100 * ONE);
        send_ray(0, 0, 0, 0, ONE, 0, 0, 100 * ONE);
        send_ray(0, 0, -4 * ONE, 0, 0, ONE, 0, 2 * ONE);
        send_ray(-4 * ONE, ONE, 0, ONE, 0, 0, 0, 100 * ONE);
        send_ray(-4 * ONE, 2 * ONE, 0, ONE, 0, 0, 0, 100 * ONE);
        send_ray(-4 * ONE, 0, 0, 0, 0, 0, 0, 100 * ONE);
        send_ray(-4 * ONE, 0, 0, ONE, 0, 0, 100 * ONE, 0);
        send_ray(-4 * ONE, 0, 0, ONE, 0, 0, 3 * ONE, 3 * ONE);
        send_ray(-4 * ONE, 0, 0, ONE, 0, 0, 5 * ONE, 5 * ONE);
        send_ray(4 * ONE, 0, 0, ONE, 0, 0, 32'sh80000000, 32'sh7fffffff);
        send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_ray(32'sh7fffffff, 0, 32'sh80000000, 3 * ONE, -ONE, ONE, 32'sh80000000,
                 32'sh7fffffff);
        send_ray(0, 0, 0, 1, 0, 0, 32'sh80000000, 32'sh7fffffff);
        send_ray(-ONE, 0, 0, 0, -ONE, 0, 32'sh80000000, 32'sh7fffffff);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    cx = 0; cy = 0; cz = 0; rad = ONE;
                end
                1:
                begin
                    cx = near_val(); cy = near_val(); cz = near_val();
                    rad = $urandom_range(ONE / 4, 6 * ONE) | (32'($urandom_range(1)) << 31);
                end
                2:
                begin
                    cx = 32'h80000000; cy = 32'h80000000; cz = 32'h80000000; rad = 32'hffffffff;
                end
                3:
                begin
                    cx = 32'h7fffffff; cy = 32'h7fffffff; cz = 32'h7fffffff; rad = 0;
                end
                default:
                begin
                    cx = near_val(); cy = near_val(); cz = near_val();
                    rad = $urandom_range(0, 6 * ONE);
                end
            endcase
            write_reg(REG_CENTER_X, cx);
            write_reg(REG_CENTER_Y, cy);
            write_reg(REG_CENTER_Z, cz);
            write_reg(REG_RADIUS, rad);
            for (int m = 0; m < 4; m++)
            begin
                idle_mode = m;
                if (phase == 1 && m == 0)
                    hold_start <= 1'b1;
                repeat (27) send_random();
            end
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("ray_sphere_intersect_unit_test passed");
        else
            $display("ray_sphere_intersect_unit_test failed");
        $finish;
    end

endmodule
